[hw/rtl/wec_pkg.sv]
package wec_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;

  typedef struct packed {
    logic [15:0] wave_height;
    logic [15:0] energy_period;
  } in_item_t;

  typedef struct packed {
    logic [23:0] power_out;
    logic [16:0] normalized_output;
  } out_item_t;

  typedef struct packed {
    logic [15:0] h;
    logic [15:0] t;
    logic        zero;
  } work_t;

  typedef struct packed {
    logic        model_select;
    logic [15:0] rated_cap;
    logic [15:0] design_height;
    logic [15:0] design_period;
  } cfg_t;

  typedef enum logic [1:0] {
    REG_MODEL_SELECT  = 2'd0,
    REG_RATED_CAP     = 2'd1,
    REG_DESIGN_HEIGHT = 2'd2,
    REG_DESIGN_PERIOD = 2'd3
  } cfg_reg_t;

  localparam logic [15:0] CAP_RST = 16'd100;
  localparam logic [15:0] DH_RST  = 16'd512;
  localparam logic [15:0] DT_RST  = 16'd2560;

  localparam logic [16:0] FRAC_ONE   = 17'd65536;
  localparam logic [22:0] NORM_LIMIT = 23'd4194304;

  localparam logic [22:0] COEF_TT = 23'd2360544;
  localparam logic [22:0] COEF_TH = 23'd3613078;
  localparam logic [22:0] COEF_HH = 23'd4210117;

  localparam logic [21:0] BRK_H  = 22'd2560000;
  localparam logic [11:0] BRK_T  = 12'd2184;
  localparam logic [14:0] PARA_H = 15'd28900;
  localparam logic [10:0] PARA_T = 11'd1690;
  localparam logic [6:0]  PARA_K = 7'd111;

  localparam logic [28:0] PARA_RECIP = 29'd351843721;
  localparam logic [47:0] PARA_HALF  = 48'd12800000;
  localparam logic [47:0] PARA_SAT   = 48'd1677747200000;

  localparam logic [30:0] EXP_ONE   = 31'h4000_0000;
  localparam logic [35:0] EXP_MAX_M = 36'd1048576;

endpackage

[hw/rtl/wec_fifo.sv]
module wec_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  logic [1:0]   cnt_r, cnt_nxt;
  logic [W-1:0] d0_r, d0_nxt;
  logic [W-1:0] d1_r, d1_nxt;
  logic         push_ok, pop_ok;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = d0_r;

  always_comb begin
    cnt_nxt = cnt_r;
    d0_nxt  = d0_r;
    d1_nxt  = d1_r;
    if (pop_ok) begin
      d0_nxt  = d1_r;
      cnt_nxt = cnt_nxt - 2'd1;
    end
    if (push_ok) begin
      if (cnt_nxt == 2'd0) begin
        d0_nxt = wdata;
      end else begin
        d1_nxt = wdata;
      end
      cnt_nxt = cnt_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d0_r <= d0_nxt;
    d1_r <= d1_nxt;
  end

endmodule

[hw/rtl/wec_front.sv]
module wec_front #(
  parameter int SW = wec_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic              in_push,
  input  wec_pkg::in_item_t in_item,
  output logic              in_full,
  input  logic              q_full,
  output logic              q_push,
  output wec_pkg::work_t    q_data
);
  import wec_pkg::*;

  localparam int          MW   = (SW < 16) ? SW : 16;
  localparam logic [15:0] MASK = 16'((32'd1 << MW) - 32'd1);

  logic [15:0] h, t;

  assign h       = in_item.wave_height & MASK;
  assign t       = in_item.energy_period & MASK;
  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  // flag samples whose result is zero in either mode
  assign q_data = '{h: h, t: t, zero: (h == 16'd0) || (t == 16'd0)};

endmodule

[hw/rtl/wec_div.sv]
module wec_div #(
  parameter int DW = 16,
  parameter int QW = 23
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] divisor,
  input  logic [DW-1:0] rem_in,
  input  logic [QW-1:0] quo_in,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_r   [QW];
  logic [QW-1:0] quo_r   [QW];
  logic [DW-1:0] rem_nxt [QW];
  logic [QW-1:0] quo_nxt [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0] rsrc;
    logic [QW-1:0] qsrc;
    logic [DW:0]   trial;
    logic          ge;
    if (i == 0) begin : g_first
      assign rsrc = rem_in;
      assign qsrc = quo_in;
    end else begin : g_next
      assign rsrc = rem_r[i-1];
      assign qsrc = quo_r[i-1];
    end
    assign trial      = {rsrc, qsrc[QW-1]};
    assign ge         = trial >= {1'b0, divisor};
    assign rem_nxt[i] = ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
    assign quo_nxt[i] = {qsrc[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r[QW-1];

endmodule

[hw/rtl/wec_back.sv]
module wec_back (
  input  logic               clk,
  input  logic               rst_n,
  input  wec_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  wec_pkg::work_t     q_data,
  output logic               q_pop,
  input  logic               o_full,
  output logic               o_push,
  output wec_pkg::out_item_t o_data
);
  import wec_pkg::*;

  localparam int LAT     = 82;
  localparam int SIDE_N  = 80;
  localparam int ST_PSAT = 4;
  localparam int ST_PFR  = 5;
  localparam int ST_NORM = 24;
  localparam int ST_X    = 28;
  localparam int SER_N   = 48;

  typedef struct packed {
    logic        zero;
    logic        hneg;
    logic        tneg;
    logic        hovf;
    logic        tovf;
    logic        psat;
    logic [16:0] pfrac;
    logic        xpos;
    logic        big;
  } side_t;

  typedef struct packed {
    logic [20:0] m;
    logic [30:0] term;
    logic [30:0] p;
    logic [30:0] q;
    logic [30:0] sum;
  } ser_t;

  logic         en;
  logic [LAT:1] valid_r;
  side_t        side_r   [1:SIDE_N];
  side_t        side_nxt [1:SIDE_N];
  side_t        side1;

  logic [37:0] a1_r;
  logic [31:0] tt1_r, hh1_r;
  logic [47:0] pos1_r, neg1_r;
  logic [22:0] k1_r;
  logic [15:0] hd1_r, td1_r;
  logic [15:0] hdiff, tdiff;
  logic        hge, tge;

  logic [43:0] b2_r;
  logic [37:0] a2_r;
  logic [47:0] diff2_r;
  logic [54:0] kh2_r;
  logic [47:0] num3_r;
  logic [47:0] dsum;
  logic [27:0] d4_r;
  logic [56:0] pmul;
  logic        brk;
  logic [16:0] pq;

  logic [22:0] hq, tq;
  logic [22:0] hm_r, tm_r;
  logic [28:0] aa_r, bb_r, cc_r;
  logic [45:0] aa_full, bb_full, cc_full;
  logic [51:0] pa_r, pb_r, pc_r;
  logic [20:0] m_r;
  logic signed [55:0] xs;
  logic [55:0] negx;
  logic [35:0] mfull;

  ser_t        ser_r   [SER_N];
  ser_t        ser_nxt [SER_N];
  logic [30:0] sq_r    [4];
  logic [30:0] sq_nxt  [4];
  logic [31:0] fround;
  logic [16:0] gfrac, frac_r;
  logic [32:0] scaled;

  assign en     = !o_full;
  assign q_pop  = en && !q_empty;
  assign o_push = en && valid_r[LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[LAT-1:1], !q_empty};
    end
  end

  // front of pipe: products and normalization set-up
  assign hge   = q_data.h >= cfg.design_height;
  assign tge   = q_data.t >= cfg.design_period;
  assign hdiff = hge ? q_data.h - cfg.design_height : cfg.design_height - q_data.h;
  assign tdiff = tge ? q_data.t - cfg.design_period : cfg.design_period - q_data.t;

  always_comb begin
    side1       = '0;
    side1.zero  = q_data.zero;
    side1.hneg  = !hge;
    side1.tneg  = !tge;
    side1.hovf  = {7'b0, hdiff} >= {cfg.design_height, 7'b0};
    side1.tovf  = {7'b0, tdiff} >= {cfg.design_period, 7'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= 38'(q_data.h) * 38'(BRK_H);
      tt1_r  <= 32'(q_data.t) * 32'(q_data.t);
      hh1_r  <= 32'(q_data.h) * 32'(q_data.h);
      pos1_r <= {32'(q_data.h) * 32'(PARA_H), 16'b0};
      neg1_r <= {32'(q_data.t) * 32'(PARA_T), 16'b0};
      k1_r   <= 23'(q_data.t) * 23'(PARA_K);
      hd1_r  <= hdiff;
      td1_r  <= tdiff;
    end
  end

  // paraboloid
  assign brk  = {6'b0, a2_r} >= b2_r;
  assign dsum = num3_r + PARA_HALF;

  // divide by 25600000: drop 13 low bits, then multiply by reciprocal of 3125
  assign pmul = 57'(d4_r) * 57'(PARA_RECIP);
  assign pq   = pmul[56:40];

  always_ff @(posedge clk) begin
    if (en) begin
      b2_r    <= 44'(tt1_r) * 44'(BRK_T);
      a2_r    <= a1_r;
      diff2_r <= (pos1_r > neg1_r) ? pos1_r - neg1_r : '0;
      kh2_r   <= 55'(k1_r) * 55'(hh1_r);
      num3_r  <= (!brk && (55'(diff2_r) > kh2_r)) ? diff2_r - 48'(kh2_r) : '0;
      d4_r    <= dsum[40:13];
    end
  end

  // gaussian normalization
  wec_div #(.DW(16), .QW(23)) u_hdiv (
    .clk     (clk),
    .en      (en),
    .divisor (cfg.design_height),
    .rem_in  ({7'b0, hd1_r[15:7]}),
    .quo_in  ({hd1_r[6:0], 16'b0}),
    .quo     (hq)
  );

  wec_div #(.DW(16), .QW(23)) u_tdiv (
    .clk     (clk),
    .en      (en),
    .divisor (cfg.design_period),
    .rem_in  ({7'b0, td1_r[15:7]}),
    .quo_in  ({td1_r[6:0], 16'b0}),
    .quo     (tq)
  );

  assign aa_full = 46'(tm_r) * 46'(tm_r);
  assign bb_full = 46'(tm_r) * 46'(hm_r);
  assign cc_full = 46'(hm_r) * 46'(hm_r);

  always_comb begin
    xs = 56'sd0 - $signed({4'b0, pa_r}) - $signed({4'b0, pc_r});
    if (side_r[ST_X-1].hneg != side_r[ST_X-1].tneg) begin
      xs = xs - $signed({4'b0, pb_r});
    end else begin
      xs = xs + $signed({4'b0, pb_r});
    end
  end

  assign negx  = 56'(-xs);
  assign mfull = negx[55:20];

  always_ff @(posedge clk) begin
    if (en) begin
      hm_r <= (side_r[ST_NORM].hovf || hq > NORM_LIMIT) ? NORM_LIMIT : hq;
      tm_r <= (side_r[ST_NORM].tovf || tq > NORM_LIMIT) ? NORM_LIMIT : tq;
      aa_r <= aa_full[44:16];
      bb_r <= bb_full[44:16];
      cc_r <= cc_full[44:16];
      pa_r <= 52'(COEF_TT) * 52'(aa_r);
      pb_r <= 52'(COEF_TH) * 52'(bb_r);
      pc_r <= 52'(COEF_HH) * 52'(cc_r);
      m_r  <= mfull[20:0];
    end
  end

  // exp(-m/16) series: multiply, reciprocal estimate, correct and accumulate
  for (genvar g = 0; g < SER_N; g++) begin : g_ser
    localparam int          K  = g / 3 + 1;
    localparam int          PH = g % 3;
    localparam logic [32:0] RK = 33'(64'd4294967296 / K);
    ser_t        sin;
    ser_t        nx;
    logic [51:0] prod;
    logic [63:0] prod2;
    logic [31:0] rem;
    logic [30:0] qf;
    if (g == 0) begin : g_first
      assign sin = '{m: m_r, term: EXP_ONE, p: '0, q: '0, sum: EXP_ONE};
    end else begin : g_next
      assign sin = ser_r[g-1];
    end
    assign prod  = 52'(sin.term) * 52'(sin.m);
    assign prod2 = 64'(sin.p) * 64'(RK);
    assign rem   = 32'(sin.p) - 32'(sin.q) * 32'(K);
    assign qf    = (rem >= 32'(K)) ? sin.q + 31'd1 : sin.q;
    always_comb begin
      nx = sin;
      case (PH)
        0: nx.p = prod[50:20];
        1: nx.q = prod2[62:32];
        default: begin
          nx.term = qf;
          nx.sum  = (K % 2 == 1) ? sin.sum - qf : sin.sum + qf;
        end
      endcase
    end
    assign ser_nxt[g] = nx;
  end

  for (genvar s = 0; s < 4; s++) begin : g_sq
    logic [30:0] src;
    logic [61:0] sqp;
    if (s == 0) begin : g_first
      assign src = ser_r[SER_N-1].sum;
    end else begin : g_next
      assign src = sq_r[s-1];
    end
    assign sqp       = 62'(src) * 62'(src);
    assign sq_nxt[s] = sqp[60:30];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ser_r <= ser_nxt;
      sq_r  <= sq_nxt;
    end
  end

  assign fround = 32'(sq_r[3]) + 32'd8192;

  always_comb begin
    if (side_r[SIDE_N].xpos) begin
      gfrac = FRAC_ONE;
    end else if (side_r[SIDE_N].big) begin
      gfrac = '0;
    end else if (fround[30:14] > FRAC_ONE) begin
      gfrac = FRAC_ONE;
    end else begin
      gfrac = fround[30:14];
    end
  end

  assign scaled = 33'(frac_r) * 33'(cfg.rated_cap) + 33'd128;

  always_ff @(posedge clk) begin
    if (en) begin
      if (side_r[SIDE_N].zero) begin
        frac_r <= '0;
      end else if (cfg.model_select) begin
        frac_r <= gfrac;
      end else begin
        frac_r <= side_r[SIDE_N].pfrac;
      end
      o_data.normalized_output <= frac_r;
      o_data.power_out         <= scaled[31:8];
    end
  end

  always_comb begin
    side_nxt[1] = side1;
    for (int i = 2; i <= SIDE_N; i++) begin
      side_nxt[i] = side_r[i-1];
    end
    side_nxt[ST_PSAT].psat = dsum >= PARA_SAT;
    side_nxt[ST_PFR].pfrac = side_r[ST_PFR-1].psat ? FRAC_ONE : pq;
    side_nxt[ST_X].xpos    = !xs[55];
    side_nxt[ST_X].big     = mfull > EXP_MAX_M;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_nxt;
    end
  end

endmodule

[hw/rtl/wave_energy_converter_power_curve.sv]
// Wave energy converter power curve. Each request carries a wave height and an
// energy period; each result gives output in kW and as a Q1.16 fraction of
// capacity. One request can be taken every cycle while the pipeline is not
// stalled. A result passes through the back pipeline, whose depth is set by the
// two long normalization dividers and the fully pipelined exponential series, and
// then enters the result queue. A full result queue stalls the back pipeline, and
// the work queue then stalls the input.
// Write registers only while the block is empty; cfg_ready is always high.
module wave_energy_converter_power_curve #(
  parameter int SAMPLE_WIDTH = wec_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  wec_pkg::in_item_t  in_item,
  input  logic               out_pop,
  output logic               out_empty,
  output wec_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import wec_pkg::*;

  cfg_t      cfg_r;
  work_t     fq_wdata;
  logic      fq_push, fq_full, fq_empty, fq_pop;
  logic [$bits(work_t)-1:0]     fq_rdata;
  out_item_t bk_data;
  logic      out_push, out_full;
  logic [$bits(out_item_t)-1:0] out_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{model_select: 1'b0, rated_cap: CAP_RST,
                 design_height: DH_RST, design_period: DT_RST};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODEL_SELECT:  cfg_r.model_select  <= cfg_data[0];
        REG_RATED_CAP:     cfg_r.rated_cap     <= cfg_data;
        REG_DESIGN_HEIGHT: cfg_r.design_height <= cfg_data;
        REG_DESIGN_PERIOD: cfg_r.design_period <= cfg_data;
        default: ;
      endcase
    end
  end

  wec_front #(.SW(SAMPLE_WIDTH)) u_front (
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .q_full  (fq_full),
    .q_push  (fq_push),
    .q_data  (fq_wdata)
  );

  wec_fifo #(.W($bits(work_t))) u_work_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata (fq_wdata),
    .pop   (fq_pop),
    .rdata (fq_rdata),
    .full  (fq_full),
    .empty (fq_empty)
  );

  wec_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (fq_empty),
    .q_data  (work_t'(fq_rdata)),
    .q_pop   (fq_pop),
    .o_full  (out_full),
    .o_push  (out_push),
    .o_data  (bk_data)
  );

  wec_fifo #(.W($bits(out_item_t))) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata (bk_data),
    .pop   (out_pop),
    .rdata (out_rdata),
    .full  (out_full),
    .empty (out_empty)
  );

  assign out_item = out_item_t'(out_rdata);

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_item.normalized_output <= FRAC_ONE)
    else $error("fraction above full scale");

  a_zero_power: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.normalized_output == 17'd0) |-> out_item.power_out == 24'd0)
    else $error("power without fraction");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full)
    else $error("result dropped at full queue");

endmodule

[tb/sv/tb_wave_energy_converter_power_curve.sv]
`timescale 1ns / 1ps

module tb_wave_energy_converter_power_curve;
  import wec_pkg::*;

  class power_curve_board;
    longint unsigned model, cap, dh, dt;
    out_item_t       expected_q[$];
    int              errors;
    int              checked;

    function new();
      model = 0;
      cap   = 100;
      dh    = 512;
      dt    = 2560;
    endfunction

    function automatic longint unsigned para_frac(longint unsigned h, longint unsigned t);
      longint unsigned pos, neg, diff, h2, k, num, f;
      if (h * 2560000 >= 2184 * t * t) return 0;
      pos = (28900 * h) << 16;
      neg = (1690 * t) << 16;
      if (pos <= neg) return 0;
      diff = pos - neg;
      h2   = h * h;
      k    = 111 * t;
      if (h2 > diff / k) return 0;
      num = diff - k * h2;
      if (num == 0) return 0;
      f = (num + 12800000) / 25600000;
      return (f > 65536) ? 65536 : f;
    endfunction

    function automatic longint norm_q16(longint unsigned v, longint unsigned d);
      longint unsigned mag;
      bit              below;
      if (d == 0) return longint'(NORM_LIMIT);
      below = (v < d);
      mag   = below ? ((d - v) << 16) / d : ((v - d) << 16) / d;
      if (mag > NORM_LIMIT) mag = NORM_LIMIT;
      return below ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint unsigned exp_neg(longint unsigned m);
      longint          sum;
      longint unsigned term, u, f, kk;
      sum  = longint'(1) << 30;
      term = longint'(1) << 30;
      for (kk = 1; kk <= 16; kk++) begin
        term = (term * m) / (kk << 20);
        if (kk[0]) sum -= longint'(term);
        else sum += longint'(term);
      end
      u = (sum > 0) ? longint'(sum) : 0;
      repeat (4) u = (u * u) >> 30;
      f = (u + 8192) >> 14;
      return (f > 65536) ? 65536 : f;
    endfunction

    function automatic longint unsigned gauss_frac(longint unsigned h, longint unsigned t);
      longint          hn, tn, a16, b16, c16, x;
      longint unsigned ha, ta, m;
      hn  = norm_q16(h, dh);
      tn  = norm_q16(t, dt);
      ha  = (hn < 0) ? -hn : hn;
      ta  = (tn < 0) ? -tn : tn;
      a16 = longint'((ta * ta) >> 16);
      c16 = longint'((ha * ha) >> 16);
      b16 = longint'((ta * ha) >> 16);
      if ((hn < 0) != (tn < 0)) b16 = -b16;
      x = -longint'(COEF_TT) * a16 + longint'(COEF_TH) * b16 - longint'(COEF_HH) * c16;
      if (x >= 0) return 65536;
      m = longint'(-x) >> 20;
      if (m > (longint'(16) << 16)) return 0;
      return exp_neg(m);
    endfunction

    function void note_request(in_item_t req);
      longint unsigned h, t, frac;
      out_item_t       res;
      h    = req.wave_height;
      t    = req.energy_period;
      frac = 0;
      if (h != 0 && t != 0) frac = model[0] ? gauss_frac(h, t) : para_frac(h, t);
      res.power_out         = 24'((frac * cap + 128) >> 8);
      res.normalized_output = 17'(frac);
      expected_q.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_res;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_res = expected_q.pop_front();
      checked++;
      if (got.power_out !== exp_res.power_out) begin
        errors++;
        if (errors <= 10)
          $display("power_out mismatch: expected %0d got %0d",
                   exp_res.power_out, got.power_out);
      end
      if (got.normalized_output !== exp_res.normalized_output) begin
        errors++;
        if (errors <= 10)
          $display("normalized_output mismatch: expected %0d got %0d",
                   exp_res.normalized_output, got.normalized_output);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk = 0;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_item;
  logic      out_pop;
  logic      out_empty;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  power_curve_board board;
  bit quiet;
  bit hold_go;
  bit long_stall;
  int sent;
  int stall_left;

  wave_energy_converter_power_curve dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_pop(out_pop), .out_empty(out_empty), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) board.check_result(out_item);
    if (!rst_n || long_stall) begin
      out_pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_pop <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    long_stall = 1;
    repeat (400) @(posedge clk);
    long_stall = 0;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_request(in_item_t req);
    int gap;
    in_push <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (in_full) @(posedge clk);
    board.note_request(req);
    sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MODEL_SELECT:  board.model = val[0];
      REG_RATED_CAP:     board.cap = val;
      REG_DESIGN_HEIGHT: board.dh = val;
      REG_DESIGN_PERIOD: board.dt = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic in_item_t random_request();
    in_item_t r;
    int       kind;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      r.wave_height   = 16'($urandom);
      r.energy_period = 16'($urandom);
    end else if (kind == 3) begin
      r.wave_height   = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
      r.energy_period = (r.wave_height == 0) ? 16'($urandom) : 16'd0;
    end else begin
      r.wave_height   = 16'($urandom_range(1,
                          32'((board.dh * 4 > 65535) ? 65535 : board.dh * 4)));
      r.energy_period = 16'($urandom_range(1,
                          32'((board.dt * 3 > 65535) ? 65535 : board.dt * 3)));
    end
    return r;
  endfunction

  logic [15:0] corner_h [13] = '{0, 0, 100, 16'hFFFF, 1, 16'hFFFF, 1, 56, 55,
                                 768, 512, 16'hFFFF, 1024};
  logic [15:0] corner_t [13] = '{0, 300, 0, 16'hFFFF, 1, 1, 16'hFFFF, 256, 256,
                                 1792, 2560, 1, 3072};
  logic [15:0] phase_cfg [7][4] = '{
    '{0, 100, 512, 2560},
    '{1, 100, 512, 2560},
    '{1, 65535, 1, 1},
    '{0, 65535, 512, 2560},
    '{1, 0, 65535, 65535},
    '{1, 1000, 256, 2048},
    '{0, 0, 65535, 1}
  };

  initial begin
    in_item_t req;
    board      = new();
    rst_n      = 1'b0;
    in_push    = 1'b0;
    in_item    = '0;
    out_pop    = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_MODEL_SELECT;
    cfg_data   = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < 7; p++) begin
      quiet = (p == 6);
      write_reg(REG_MODEL_SELECT, phase_cfg[p][0]);
      write_reg(REG_RATED_CAP, phase_cfg[p][1]);
      write_reg(REG_DESIGN_HEIGHT, phase_cfg[p][2]);
      write_reg(REG_DESIGN_PERIOD, phase_cfg[p][3]);
      cfg_valid <= 1'b0;
      if (p < 2) begin
        for (int i = 0; i < 13; i++) begin
          req.wave_height   = corner_h[i];
          req.energy_period = corner_t[i];
          send_request(req);
        end
      end
      for (int i = 0; i < 160; i++) begin
        if (p == 1 && i == 20) hold_go = 1;
        send_request(random_request());
      end
      drain();
    end
    $display("covered %0d requests over 7 register settings, %0d results checked",
             sent, board.checked);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
